### rtl/core/mkcf_pkg.sv
// Shared types and constants of the multi-kernel convolution filter.
package mkcf_pkg;

   localparam int MAX_WIDTH_DEF   = 1024;
   localparam int MAX_HEIGHT_DEF  = 1024;
   localparam int MAX_KERNEL_DEF  = 9;
   localparam int MAX_KERNELS_DEF = 2;

   localparam int CNT_W      = 21;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;
   localparam int DIV_W      = 10;
   localparam int PIX_MAX    = 255;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_HALF  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_COUNT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVISOR      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS         = 3'd5;

   localparam logic [1:0] OP_PIXEL = 2'd0;
   localparam logic [1:0] OP_DRAIN = 2'd1;
   localparam logic [1:0] OP_COEF  = 2'd2;

   typedef struct packed {
      logic [1:0]        op;
      logic [7:0]        pixel;
      logic [7:0]        coef_index;
      logic signed [7:0] coef_value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_pixel;
      logic       frame_last;
   } rsp_type;

endpackage

### rtl/core/mkcf_divider.sv
// Restoring divider, one quotient bit per cycle.
module mkcf_divider #(
   parameter int NW = 24,
   parameter int DW = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          busy,
   output logic [NW-1:0] quo,
   output logic [DW-1:0] rem
);

   localparam int CW = $clog2(NW + 1);

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   shifted;
   logic [DW:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      shifted = {rem_ff, quo_ff[NW-1]};
      trial   = shifted - {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NW);
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         if (!trial[DW]) begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

### rtl/core/multi_kernel_convolution_filter.sv
// Streaming convolution filter: one or two square kernels, absolute sums, divide, bias, clamp.
// A pixel or drain word yields one output once enough words are stored to fill the window.
// One serial divider (NW bits, 23 at the defaults) is used twice per output, first to split
// the output position into row and column, then to scale the total, and one multiply-
// accumulate takes a window tap per cycle from the line memory and the coefficient memory.
// Words that emit nothing return to idle after the store; coefficient loads are taken in idle.
// A new word is taken while the previous result waits on the output register. Coefficients
// must be loaded before the first output that uses them; no clearing pass is run after reset.
module multi_kernel_convolution_filter #(
   parameter int MAX_WIDTH   = mkcf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT  = mkcf_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_KERNEL  = mkcf_pkg::MAX_KERNEL_DEF,
   parameter int MAX_KERNELS = mkcf_pkg::MAX_KERNELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  mkcf_pkg::req_type                 req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output mkcf_pkg::rsp_type                 rsp_word,
   input  logic                              csr_we,
   input  logic [mkcf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mkcf_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import mkcf_pkg::*;

   localparam int LINE_DEPTH = MAX_KERNEL * MAX_WIDTH;
   localparam int COEF_DEPTH = MAX_KERNELS * MAX_KERNEL * MAX_KERNEL;
   localparam int LA_W = $clog2(LINE_DEPTH);
   localparam int LD_W = $clog2(LINE_DEPTH + 1);
   localparam int CA_W = $clog2(COEF_DEPTH);
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int HW   = $clog2(MAX_HEIGHT + 1);
   localparam int TP_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int MAX_HALF = (MAX_KERNEL - 1) / 2;
   localparam int SUM_MAX  = MAX_KERNEL * MAX_KERNEL * PIX_MAX * 128;
   localparam int SUM_W    = $clog2(SUM_MAX + 1) + 1;
   localparam int TOT_W    = $clog2(MAX_KERNELS * SUM_MAX + 1);
   localparam int NW   = (CNT_W > TOT_W) ? CNT_W : TOT_W;
   localparam int DW   = (WW > DIV_W) ? WW : DIV_W;
   localparam int CW_W = (WW > CSR_DATA_W) ? WW : CSR_DATA_W;
   localparam int CH_W = (HW > CSR_DATA_W) ? HW : CSR_DATA_W;
   localparam int CMP_A = (CNT_W > TP_W) ? CNT_W : TP_W;
   localparam int CMP_W = (CMP_A > LD_W) ? CMP_A : LD_W;
   localparam int YW = $clog2(MAX_HEIGHT + MAX_KERNEL) + 1;
   localparam int XW = $clog2(MAX_WIDTH + MAX_KERNEL) + 1;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MUL1   = 4'd1;
   localparam logic [3:0] ST_MUL2   = 4'd2;
   localparam logic [3:0] ST_STORE  = 4'd3;
   localparam logic [3:0] ST_DIVXY  = 4'd4;
   localparam logic [3:0] ST_TAPS   = 4'd5;
   localparam logic [3:0] ST_FLUSH  = 4'd6;
   localparam logic [3:0] ST_DIVOUT = 4'd7;

   // configuration
   logic [10:0]       fw_ff, fh_ff;
   logic [2:0]        kh_ff;
   logic [1:0]        kcnt_ff;
   logic [9:0]        div_ff;
   logic signed [8:0] bias_ff;

   logic [3:0]          state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [LA_W-1:0]     wr_addr_ff, wr_addr_in;
   logic [1:0]          op_ff, op_in;
   logic [7:0]          pixel_ff, pixel_in;
   logic [TP_W-1:0]     total_px_ff, total_px_in;
   logic [LD_W-1:0]     lag_ff, lag_in;
   logic [CNT_W-1:0]    o_ff, o_in;
   logic signed [YW-1:0] ys_ff, ys_in, yy_ff, yy_in;
   logic signed [XW-1:0] xs_ff, xs_in, xx_ff, xx_in;
   logic [3:0]          i_ff, i_in, j_ff, j_in;
   logic [1:0]          k_ff, k_in;
   logic [CA_W-1:0]     ci_ff, ci_in;
   logic [LD_W-1:0]     row_d_ff, row_d_in, d_ff, d_in;
   logic                s1_valid_ff, s1_valid_in, s1_in_ff, s1_in_in, s1_last_ff, s1_last_in;
   logic                s2_valid_ff, s2_last_ff;
   logic signed [16:0]  prod_ff;
   logic signed [SUM_W-1:0] sum_ff, sum_in, sum_acc;
   logic [TOT_W-1:0]    total_ff, total_in;
   logic [SUM_W-1:0]    sum_mag;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [7:0]          line_rd_ff;
   logic signed [7:0]   coef_rd_ff;
   logic [7:0]          line_mem [LINE_DEPTH];
   logic [7:0]          coef_mem [COEF_DEPTH];

   logic [WW-1:0]    w_sat;
   logic [HW-1:0]    h_sat;
   logic [2:0]       hf_sat;
   logic [1:0]       kc_sat;
   logic [9:0]       dv_sat;
   logic [3:0]       side_m1;
   logic [CMP_W-1:0] p_c, lag_c, tp_c, o_c;
   logic [CNT_W-1:0] o_now, cnt_inc;
   logic [LA_W-1:0]  addr_inc;
   logic [LD_W:0]    rd_diff;
   logic [LA_W-1:0]  rd_addr;
   logic             yy_ok, xx_ok, tap_last;
   logic             accept, store_en;
   logic             div_start, div_busy;
   logic [NW-1:0]    div_num, div_quo;
   logic [DW-1:0]    div_den, div_rem;
   logic [8:0]       q_sat;
   logic signed [10:0] res;

   // saturated register views
   always_comb begin
      if (fw_ff == 11'd0) w_sat = WW'(1);
      else if (CW_W'(fw_ff) > CW_W'(MAX_WIDTH)) w_sat = WW'(MAX_WIDTH);
      else w_sat = WW'(fw_ff);
      if (fh_ff == 11'd0) h_sat = HW'(1);
      else if (CH_W'(fh_ff) > CH_W'(MAX_HEIGHT)) h_sat = HW'(MAX_HEIGHT);
      else h_sat = HW'(fh_ff);
      hf_sat = (kh_ff > 3'(MAX_HALF)) ? 3'(MAX_HALF) : kh_ff;
      if (kcnt_ff == 2'd0) kc_sat = 2'd1;
      else if (kcnt_ff > 2'(MAX_KERNELS)) kc_sat = 2'(MAX_KERNELS);
      else kc_sat = kcnt_ff;
      dv_sat = (div_ff == 10'd0) ? 10'd1 : div_ff;
   end

   assign side_m1  = {hf_sat, 1'b0};
   assign accept   = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign p_c      = CMP_W'(cnt_ff);
   assign lag_c    = CMP_W'(lag_ff);
   assign tp_c     = CMP_W'(total_px_ff);
   assign o_now    = cnt_ff - CNT_W'(lag_ff);
   assign o_c      = CMP_W'(o_ff);
   assign cnt_inc  = cnt_ff + CNT_W'(1);
   assign addr_inc = (cnt_ff == {CNT_W{1'b1}} || wr_addr_ff == LA_W'(LINE_DEPTH - 1)) ?
                     '0 : wr_addr_ff + LA_W'(1);
   assign store_en = (state_ff == ST_STORE) && (p_c < tp_c);

   // window tap address: d steps back from the newest stored pixel
   always_comb begin
      rd_diff = (LD_W+1)'(wr_addr_ff) - (LD_W+1)'(d_ff);
      if (rd_diff[LD_W]) rd_diff = rd_diff + (LD_W+1)'(LINE_DEPTH);
      rd_addr = rd_diff[LA_W-1:0];
   end

   assign yy_ok    = !yy_ff[YW-1] && (yy_ff[YW-2:0] < (YW-1)'(h_sat));
   assign xx_ok    = !xx_ff[XW-1] && (xx_ff[XW-2:0] < (XW-1)'(w_sat));
   assign tap_last = (i_ff == side_m1) && (j_ff == side_m1);

   assign sum_acc = sum_ff + {{(SUM_W-17){prod_ff[16]}}, prod_ff};
   assign sum_mag = sum_acc[SUM_W-1] ? -sum_acc : sum_acc;

   assign div_start = (state_ff == ST_STORE && p_c >= lag_c && CMP_W'(o_now) < tp_c) ||
                      (state_ff == ST_FLUSH && !s1_valid_ff && !s2_valid_ff);
   assign div_num   = (state_ff == ST_STORE) ? NW'(o_now) : NW'(total_ff);
   assign div_den   = (state_ff == ST_STORE) ? DW'(w_sat) : DW'(dv_sat);

   always_comb begin
      q_sat = (div_quo > NW'(510)) ? 9'd511 : div_quo[8:0];
      res   = $signed({2'b00, q_sat}) + $signed({{2{bias_ff[8]}}, bias_ff});
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      wr_addr_in  = wr_addr_ff;
      op_in       = op_ff;
      pixel_in    = pixel_ff;
      total_px_in = total_px_ff;
      lag_in      = lag_ff;
      o_in        = o_ff;
      ys_in       = ys_ff;
      xs_in       = xs_ff;
      yy_in       = yy_ff;
      xx_in       = xx_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      ci_in       = ci_ff;
      row_d_in    = row_d_ff;
      d_in        = d_ff;
      sum_in      = sum_ff;
      total_in    = total_ff;
      s1_valid_in = 1'b0;
      s1_in_in    = s1_in_ff;
      s1_last_in  = s1_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in      = rsp_ff;

      if (s2_valid_ff) begin
         if (s2_last_ff) begin
            total_in = total_ff + TOT_W'(sum_mag[SUM_W-2:0]);
            sum_in   = '0;
         end else begin
            sum_in = sum_acc;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_word.op == OP_PIXEL || req_word.op == OP_DRAIN)) begin
               op_in    = req_word.op;
               pixel_in = req_word.pixel;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            total_px_in = TP_W'(TP_W'(w_sat) * TP_W'(h_sat));
            state_in    = ST_MUL2;
         end
         ST_MUL2: begin
            lag_in   = LD_W'(LD_W'(hf_sat) * LD_W'(w_sat)) + LD_W'(hf_sat);
            state_in = ST_STORE;
         end
         ST_STORE: begin
            o_in = o_now;
            if (p_c < lag_c) begin
               cnt_in     = cnt_inc;
               wr_addr_in = addr_inc;
               state_in   = ST_IDLE;
            end else if (CMP_W'(o_now) >= tp_c) begin
               // stale position after a register change
               cnt_in     = '0;
               wr_addr_in = '0;
               state_in   = ST_IDLE;
            end else begin
               state_in = ST_DIVXY;
            end
         end
         ST_DIVXY: begin
            if (!div_busy) begin
               ys_in    = YW'(div_quo) - YW'(hf_sat);
               xs_in    = XW'(div_rem) - XW'(hf_sat);
               yy_in    = YW'(div_quo) - YW'(hf_sat);
               xx_in    = XW'(div_rem) - XW'(hf_sat);
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               ci_in    = '0;
               row_d_in = {lag_ff[LD_W-2:0], 1'b0};
               d_in     = {lag_ff[LD_W-2:0], 1'b0};
               sum_in   = '0;
               total_in = '0;
               state_in = ST_TAPS;
            end
         end
         ST_TAPS: begin
            s1_valid_in = 1'b1;
            s1_in_in    = yy_ok && xx_ok;
            s1_last_in  = tap_last;
            ci_in       = ci_ff + CA_W'(1);
            if (i_ff != side_m1) begin
               i_in  = i_ff + 4'd1;
               xx_in = xx_ff + XW'(1);
               d_in  = d_ff - LD_W'(1);
            end else begin
               i_in  = '0;
               xx_in = xs_ff;
               if (j_ff != side_m1) begin
                  j_in     = j_ff + 4'd1;
                  yy_in    = yy_ff + YW'(1);
                  row_d_in = row_d_ff - LD_W'(w_sat);
                  d_in     = row_d_ff - LD_W'(w_sat);
               end else begin
                  j_in     = '0;
                  yy_in    = ys_ff;
                  row_d_in = {lag_ff[LD_W-2:0], 1'b0};
                  d_in     = {lag_ff[LD_W-2:0], 1'b0};
                  k_in     = k_ff + 2'd1;
                  if (k_ff == kc_sat - 2'd1) state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!s1_valid_ff && !s2_valid_ff) state_in = ST_DIVOUT;
         end
         ST_DIVOUT: begin
            if (!div_busy && (!rsp_valid_ff || rsp_ready)) begin
               rsp_valid_in = 1'b1;
               if (res < 0) rsp_in.out_pixel = 8'd0;
               else if (res > 11'sd255) rsp_in.out_pixel = 8'(PIX_MAX);
               else rsp_in.out_pixel = res[7:0];
               rsp_in.frame_last = (o_c == tp_c - CMP_W'(1));
               if (o_c == tp_c - CMP_W'(1)) begin
                  cnt_in     = '0;
                  wr_addr_in = '0;
               end else begin
                  cnt_in     = cnt_inc;
                  wr_addr_in = addr_inc;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         wr_addr_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fw_ff        <= 11'd320;
         fh_ff        <= 11'd240;
         kh_ff        <= 3'd1;
         kcnt_ff      <= 2'd1;
         div_ff       <= 10'd1;
         bias_ff      <= 9'sd0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         wr_addr_ff   <= wr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  fw_ff   <= csr_wdata;
               CSR_FRAME_HEIGHT: fh_ff   <= csr_wdata;
               CSR_KERNEL_HALF:  kh_ff   <= csr_wdata[2:0];
               CSR_KERNEL_COUNT: kcnt_ff <= csr_wdata[1:0];
               CSR_DIVISOR:      div_ff  <= csr_wdata[9:0];
               CSR_BIAS:         bias_ff <= csr_wdata[8:0];
               default: ;
            endcase
         end
      end
      op_ff       <= op_in;
      pixel_ff    <= pixel_in;
      total_px_ff <= total_px_in;
      lag_ff      <= lag_in;
      o_ff        <= o_in;
      ys_ff       <= ys_in;
      xs_ff       <= xs_in;
      yy_ff       <= yy_in;
      xx_ff       <= xx_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      ci_ff       <= ci_in;
      row_d_ff    <= row_d_in;
      d_ff        <= d_in;
      s1_in_ff    <= s1_in_in;
      s1_last_ff  <= s1_last_in;
      s2_last_ff  <= s1_last_ff;
      prod_ff     <= s1_in_ff ? $signed({1'b0, line_rd_ff}) * coef_rd_ff : 17'sd0;
      sum_ff      <= sum_in;
      total_ff    <= total_in;
      rsp_ff      <= rsp_in;
   end

   // line memory: one write per stored word, one tap read per cycle
   always_ff @(posedge clock) begin
      if (store_en) begin
         line_mem[wr_addr_ff] <= (op_ff == OP_PIXEL) ? pixel_ff : 8'd0;
      end
      line_rd_ff <= line_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (accept && req_word.op == OP_COEF && {1'b0, req_word.coef_index} < 9'(COEF_DEPTH)) begin
         coef_mem[CA_W'(req_word.coef_index)] <= req_word.coef_value;
      end
      coef_rd_ff <= coef_mem[ci_ff];
   end

   mkcf_divider #(
      .NW (NW),
      .DW (DW)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
